### design/pps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pps_pkg
// shared widths, register indexes and defaults of the sphere projection core
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int COORD_W  = 32;          // signed coordinate
  localparam int DIFF_W   = COORD_W + 1; // point minus centre
  localparam int MAG_W    = COORD_W;     // magnitude of an offset
  localparam int RAD_W    = 31;          // unsigned radius
  localparam int SQ_W     = 2 * MAG_W;   // one squared offset
  localparam int SUM_W    = SQ_W + 2;    // sum of three squares
  localparam int ROOT_W   = SUM_W / 2;   // integer square root
  localparam int PROD_W   = MAG_W + RAD_W;
  localparam int NUM_W    = PROD_W + 1;  // dividend with rounding term
  localparam int QUO_W    = RAD_W;       // quotient never exceeds the radius

  localparam int FRAC_BITS_DEF = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = COORD_W;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd3;

endpackage
`default_nettype wire

### design/pps_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pps_sqrt
// pipelined integer square root, one result bit per register stage
// ----------------------------------------------------------------------------
module pps_sqrt (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [pps_pkg::SUM_W-1:0]  rad_i,
  output logic      [pps_pkg::ROOT_W-1:0] root_o
);

  localparam int RW = pps_pkg::ROOT_W;
  localparam int TW = pps_pkg::SUM_W + 2;

  logic [TW-1:0] rem_r  [0:RW-1];
  logic [RW-1:0] root_r [0:RW-1];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int B = RW - 1 - k;
    logic [TW-1:0] cur_rem;
    logic [RW-1:0] cur_root;
    logic [TW-1:0] trial;
    logic [TW-1:0] rem_nxt;
    logic [RW-1:0] root_nxt;

    if (k == 0) begin : g_first
      assign cur_rem  = TW'(rad_i);
      assign cur_root = '0;
    end else begin : g_rest
      assign cur_rem  = rem_r[k-1];
      assign cur_root = root_r[k-1];
    end

    // (r + 2^b)^2 - r^2 = r * 2^(b+1) + 2^(2b)
    always_comb begin
      trial    = (TW'(cur_root) << (B + 1)) | (TW'(1) << (2 * B));
      rem_nxt  = cur_rem;
      root_nxt = cur_root;
      if (cur_rem >= trial) begin
        rem_nxt  = cur_rem - trial;
        root_nxt = cur_root | (RW'(1) << B);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
      end
    end
  end

  assign root_o = root_r[RW-1];

endmodule
`default_nettype wire

### design/pps_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pps_div
// pipelined restoring divider, one quotient bit per register stage
// ----------------------------------------------------------------------------
module pps_div (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [pps_pkg::NUM_W-1:0]  num_i,
  input  wire logic [pps_pkg::ROOT_W-1:0] den_i,
  output logic      [pps_pkg::QUO_W-1:0]  quo_o
);

  localparam int NW = pps_pkg::NUM_W;
  localparam int DW = pps_pkg::ROOT_W;
  localparam int QW = pps_pkg::QUO_W;

  logic [NW-1:0] rem_r [0:QW-1];
  logic [DW-1:0] den_r [0:QW-1];
  logic [QW-1:0] quo_r [0:QW-1];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic [NW-1:0] cur_rem;
    logic [DW-1:0] cur_den;
    logic [QW-1:0] cur_quo;
    logic [NW-1:0] shifted;
    logic [NW-1:0] rem_nxt;
    logic [QW-1:0] quo_nxt;

    if (k == 0) begin : g_first
      assign cur_rem = num_i;
      assign cur_den = den_i;
      assign cur_quo = '0;
    end else begin : g_rest
      assign cur_rem = rem_r[k-1];
      assign cur_den = den_r[k-1];
      assign cur_quo = quo_r[k-1];
    end

    always_comb begin
      shifted = NW'(cur_den) << B;
      rem_nxt = cur_rem;
      quo_nxt = cur_quo;
      if (cur_rem >= shifted) begin
        rem_nxt = cur_rem - shifted;
        quo_nxt = cur_quo | (QW'(1) << B);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        den_r[k] <= cur_den;
        quo_r[k] <= quo_nxt;
      end
    end
  end

  assign quo_o = quo_r[QW-1];

endmodule
`default_nettype wire

### design/project_point_onto_sphere_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// project_point_onto_sphere_core
// moves each vertex radially onto a sphere of configured centre and radius
// ----------------------------------------------------------------------------
// pipeline: 4 front stages, 33 square root stages, 1 rounding stage,
//   31 divider stages and the output register
// throughput: one vertex per cycle, set by the fully pipelined root and
//   divider lanes; the whole pipe holds while an output transfer is stalled
// reset: synchronous, active low; clears valid bits, centre to zero and
//   radius to one in the configured fraction format
// ----------------------------------------------------------------------------
module project_point_onto_sphere_core #(
  parameter int FRAC_BITS = pps_pkg::FRAC_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // configuration
  input  wire logic                           cfg_we,
  input  wire logic [pps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pps_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // vertex stream
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [95:0]                    in_tdata,  // point_x, point_y, point_z
  // projected stream
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic      [95:0]                    out_tdata, // proj_x, proj_y, proj_z
  output logic      [0:0]                     out_tuser  // zero_length
);

  localparam int CW  = pps_pkg::COORD_W;
  localparam int DFW = pps_pkg::DIFF_W;
  localparam int MW  = pps_pkg::MAG_W;
  localparam int RW  = pps_pkg::RAD_W;
  localparam int PW  = pps_pkg::PROD_W;
  localparam int NW  = pps_pkg::NUM_W;
  localparam int LW  = pps_pkg::ROOT_W;
  localparam int QW  = pps_pkg::QUO_W;
  localparam int SQRT_LAT = pps_pkg::ROOT_W;
  localparam int DIV_LAT  = pps_pkg::QUO_W;

  // sideband that travels beside the square root
  typedef struct packed {
    logic                   valid;
    logic                   zero;
    logic [2:0]             neg;
    logic [2:0][PW-1:0]     prod;
  } root_side_t;

  // sideband that travels beside the dividers
  typedef struct packed {
    logic       valid;
    logic       zero;
    logic [2:0] neg;
  } div_side_t;

  // ---------------------------------------------------------------- config
  logic signed [CW-1:0] cen_r [0:2];
  logic        [RW-1:0] radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cen_r[0] <= '0;
      cen_r[1] <= '0;
      cen_r[2] <= '0;
      radius_r <= RW'(1) << FRAC_BITS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pps_pkg::CFG_CENTER_X: cen_r[0] <= cfg_wdata;
        pps_pkg::CFG_CENTER_Y: cen_r[1] <= cfg_wdata;
        pps_pkg::CFG_CENTER_Z: cen_r[2] <= cfg_wdata;
        pps_pkg::CFG_RADIUS:   radius_r <= cfg_wdata[RW-1:0];
        default: ;
      endcase
    end
  end

  // whole pipe moves when the output register is free or being emptied
  logic en;
  logic out_valid_r;
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // ---------------------------------------------------------------- s1: offset
  logic                  v1_r;
  logic signed [DFW-1:0] d1_r [0:2];

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d1_r[i] <= $signed({in_tdata[i*CW+CW-1], in_tdata[i*CW +: CW]})
                 - $signed({cen_r[i][CW-1], cen_r[i]});
      end
    end
  end

  // ---------------------------------------------------------------- s2: magnitude
  logic          v2_r;
  logic          zero2_r;
  logic [2:0]    neg2_r;
  logic [MW-1:0] mag2_r [0:2];

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero2_r <= (d1_r[0] == '0) && (d1_r[1] == '0) && (d1_r[2] == '0);
      for (int i = 0; i < 3; i++) begin
        neg2_r[i] <= d1_r[i][DFW-1];
        mag2_r[i] <= d1_r[i][DFW-1] ? MW'(-d1_r[i]) : MW'(d1_r[i]);
      end
    end
  end

  // ---------------------------------------------------------------- s3: products
  logic                      v3_r;
  logic                      zero3_r;
  logic [2:0]                neg3_r;
  logic [pps_pkg::SQ_W-1:0]  sq3_r [0:2];
  logic [2:0][PW-1:0]        prod3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero3_r <= zero2_r;
      neg3_r  <= neg2_r;
      for (int i = 0; i < 3; i++) begin
        sq3_r[i]   <= pps_pkg::SQ_W'(mag2_r[i]) * pps_pkg::SQ_W'(mag2_r[i]);
        prod3_r[i] <= PW'(mag2_r[i]) * PW'(radius_r);
      end
    end
  end

  // ---------------------------------------------------------------- s4: sum of squares
  root_side_t                side4_r;
  logic [pps_pkg::SUM_W-1:0] sum4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) side4_r.valid <= 1'b0;
    else if (en) side4_r.valid <= v3_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side4_r.zero <= zero3_r;
      side4_r.neg  <= neg3_r;
      side4_r.prod <= prod3_r;
      sum4_r <= pps_pkg::SUM_W'(sq3_r[0]) + pps_pkg::SUM_W'(sq3_r[1])
              + pps_pkg::SUM_W'(sq3_r[2]);
    end
  end

  // ---------------------------------------------------------------- length
  logic [LW-1:0] len;

  pps_sqrt u_sqrt (
    .clk    (clk),
    .en     (en),
    .rad_i  (sum4_r),
    .root_o (len)
  );

  root_side_t rside_r [0:SQRT_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      rside_r[0].zero <= side4_r.zero;
      rside_r[0].neg  <= side4_r.neg;
      rside_r[0].prod <= side4_r.prod;
      for (int i = 1; i < SQRT_LAT; i++) begin
        rside_r[i].zero <= rside_r[i-1].zero;
        rside_r[i].neg  <= rside_r[i-1].neg;
        rside_r[i].prod <= rside_r[i-1].prod;
      end
    end
    if (!rst_n) begin
      for (int i = 0; i < SQRT_LAT; i++) rside_r[i].valid <= 1'b0;
    end else if (en) begin
      rside_r[0].valid <= side4_r.valid;
      for (int i = 1; i < SQRT_LAT; i++) rside_r[i].valid <= rside_r[i-1].valid;
    end
  end

  // ---------------------------------------------------------------- s5: rounding term
  div_side_t     side5_r;
  logic [NW-1:0] num5_r [0:2];
  logic [LW-1:0] len5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) side5_r.valid <= 1'b0;
    else if (en) side5_r.valid <= rside_r[SQRT_LAT-1].valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side5_r.zero <= rside_r[SQRT_LAT-1].zero;
      side5_r.neg  <= rside_r[SQRT_LAT-1].neg;
      len5_r       <= len;
      // half the length gives round to nearest, ties away from zero
      for (int i = 0; i < 3; i++) begin
        num5_r[i] <= NW'(rside_r[SQRT_LAT-1].prod[i]) + NW'(len >> 1);
      end
    end
  end

  // ---------------------------------------------------------------- scaling lanes
  logic [QW-1:0] quo [0:2];

  for (genvar g = 0; g < 3; g++) begin : g_lane
    pps_div u_div (
      .clk   (clk),
      .en    (en),
      .num_i (num5_r[g]),
      .den_i (len5_r),
      .quo_o (quo[g])
    );
  end

  div_side_t dside_r [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      dside_r[0].zero <= side5_r.zero;
      dside_r[0].neg  <= side5_r.neg;
      for (int i = 1; i < DIV_LAT; i++) begin
        dside_r[i].zero <= dside_r[i-1].zero;
        dside_r[i].neg  <= dside_r[i-1].neg;
      end
    end
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) dside_r[i].valid <= 1'b0;
    end else if (en) begin
      dside_r[0].valid <= side5_r.valid;
      for (int i = 1; i < DIV_LAT; i++) dside_r[i].valid <= dside_r[i-1].valid;
    end
  end

  // ---------------------------------------------------------------- re-centre and saturate
  div_side_t            dlast;
  logic signed [DFW-1:0] sum_c [0:2];
  logic        [CW-1:0]  proj_nxt [0:2];

  assign dlast = dside_r[DIV_LAT-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // quotient stays below 2^31, so the 33 bit sum cannot wrap
      if (dlast.neg[i]) begin
        sum_c[i] = $signed({cen_r[i][CW-1], cen_r[i]}) - $signed({2'b00, quo[i]});
      end else begin
        sum_c[i] = $signed({cen_r[i][CW-1], cen_r[i]}) + $signed({2'b00, quo[i]});
      end
      if (dlast.zero) begin
        proj_nxt[i] = cen_r[i];
      end else if (sum_c[i][DFW-1] != sum_c[i][DFW-2]) begin
        proj_nxt[i] = sum_c[i][DFW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end else begin
        proj_nxt[i] = sum_c[i][CW-1:0];
      end
    end
  end

  // ---------------------------------------------------------------- output register
  logic [95:0] out_data_r;
  logic        out_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= dlast.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= {proj_nxt[2], proj_nxt[1], proj_nxt[0]};
      out_zero_r <= dlast.zero;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_zero_r;

endmodule
`default_nettype wire

### dv/project_point_onto_sphere_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// project_point_onto_sphere_core_tb
// self-checking bench: random and directed vertices are streamed through the
// core under several centre/radius settings and handshake stall patterns; an
// in-bench fixed-point predictor computes each projected vertex
// ----------------------------------------------------------------------------
module project_point_onto_sphere_core_tb;

  localparam int LATENCY   = 70;
  localparam int MAX_CYCLE = 400000;

  typedef struct packed {
    logic [31:0] z;
    logic [31:0] y;
    logic [31:0] x;
  } vertex_t;

  typedef struct {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic        zero_len;
  } proj_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [pps_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [pps_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [95:0] in_tdata = '0;   // point_x, point_y, point_z
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [95:0] out_tdata;       // proj_x, proj_y, proj_z
  logic [0:0] out_tuser;        // zero_length

  project_point_onto_sphere_core dut (.*);

  always #4 clk = ~clk;

  // predictor copy of the register file
  logic signed [31:0] ctr_x = '0, ctr_y = '0, ctr_z = '0;
  logic [30:0] radius = 31'd65536;

  vertex_t pending_vertices[$];
  proj_t   expected_proj[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit recv_hold = 1'b0;
  int errors = 0;
  int cycles = 0;

  // floor(sqrt(s)) for s below 2^66, bit by bit
  function automatic logic [32:0] isqrt66(input logic [65:0] s);
    logic [32:0] r;
    logic [32:0] t;
    r = '0;
    for (int b = 32; b >= 0; b--) begin
      t = r | (33'd1 << b);
      if ({t, 1'b0} != 0 && 66'(t) * 66'(t) <= s) r = t;
    end
    return r;
  endfunction

  function automatic logic [31:0] scale_axis(input logic signed [31:0] c,
                                             input logic signed [32:0] d,
                                             input logic [32:0] len);
    logic [32:0] mag;
    logic [64:0] q;
    logic signed [66:0] v;
    mag = d < 0 ? -d : d;
    q = (65'(mag) * 65'(radius) + 65'(len >> 1)) / 65'(len);
    if (q > (65'd1 << 33)) return d < 0 ? 32'h8000_0000 : 32'h7fff_ffff;
    v = d < 0 ? 67'(c) - $signed({2'b0, q}) : 67'(c) + $signed({2'b0, q});
    if (v > 67'sd2147483647) return 32'h7fff_ffff;
    if (v < -67'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic proj_t project_vertex(input vertex_t p);
    proj_t r;
    logic signed [32:0] dx, dy, dz;
    logic [65:0] sum;
    logic [32:0] len;
    dx = 33'($signed(p.x)) - 33'(ctr_x);
    dy = 33'($signed(p.y)) - 33'(ctr_y);
    dz = 33'($signed(p.z)) - 33'(ctr_z);
    if (dx == 0 && dy == 0 && dz == 0) begin
      r.px = ctr_x; r.py = ctr_y; r.pz = ctr_z; r.zero_len = 1'b1;
      return r;
    end
    sum = 66'(dx) * 66'(dx) + 66'(dy) * 66'(dy) + 66'(dz) * 66'(dz);
    len = isqrt66(sum);
    r.px = scale_axis(ctr_x, dx, len);
    r.py = scale_axis(ctr_y, dy, len);
    r.pz = scale_axis(ctr_z, dz, len);
    r.zero_len = 1'b0;
    return r;
  endfunction

  // driver: one nonblocking update of in_tvalid per edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_proj.push_back(project_vertex(vertex_t'(in_tdata)));
        void'(pending_vertices.pop_front());
      end
      if (!in_tvalid || in_tready) begin
        if (pending_vertices.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pending_vertices[0];
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_proj.size() == 0) begin
          $error("unexpected transfer %h", out_tdata);
          errors++;
        end else begin
          proj_t e;
          e = expected_proj.pop_front();
          if (out_tdata[31:0] !== e.px) begin
            $error("proj_x exp %h got %h", e.px, out_tdata[31:0]); errors++;
          end
          if (out_tdata[63:32] !== e.py) begin
            $error("proj_y exp %h got %h", e.py, out_tdata[63:32]); errors++;
          end
          if (out_tdata[95:64] !== e.pz) begin
            $error("proj_z exp %h got %h", e.pz, out_tdata[95:64]); errors++;
          end
          if (out_tuser[0] !== e.zero_len) begin
            $error("zero_length exp %b got %b", e.zero_len, out_tuser[0]); errors++;
          end
        end
      end
      out_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end
    if (cycles > MAX_CYCLE) begin
      $display("[project_point_onto_sphere_core] ERROR");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_vertices.size() != 0 || in_tvalid || expected_proj.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [pps_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      pps_pkg::CFG_CENTER_X: ctr_x = val;
      pps_pkg::CFG_CENTER_Y: ctr_y = val;
      pps_pkg::CFG_CENTER_Z: ctr_z = val;
      pps_pkg::CFG_RADIUS:   radius = val[30:0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return {{16{1'b0}}, 16'($urandom())};           // small positive
      2: return {{12{1'b1}}, 20'($urandom())};           // small negative
      3: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($signed(ctr_x)) + $signed(32'($urandom_range(4095)) - 2048);
    endcase
  endfunction

  task automatic queue_random(input int n);
    vertex_t v;
    for (int i = 0; i < n; i++) begin
      v.x = rand_coord(); v.y = rand_coord(); v.z = rand_coord();
      if ($urandom_range(31) == 0) begin
        v.x = ctr_x; v.y = ctr_y; v.z = ctr_z;    // vertex on the centre
      end
      pending_vertices.push_back(v);
    end
  endtask

  initial begin
    vertex_t v;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, centre point, single axes, default settings
    pending_vertices.push_back('{32'h0, 32'h0, 32'h0});
    pending_vertices.push_back('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
    pending_vertices.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    pending_vertices.push_back('{32'h0, 32'h0, 32'h0001_0000});
    pending_vertices.push_back('{32'h0, 32'hffff_0000, 32'h0});
    pending_vertices.push_back('{32'h1, 32'h0, 32'h0});
    pending_vertices.push_back('{32'h8000_0000, 32'h7fff_ffff, 32'h0});
    pending_vertices.push_back('{32'hffff_ffff, 32'h1, 32'hffff_ffff});
    wait_drained();

    // extreme settings: far corner centre, largest radius -> saturation
    write_reg(pps_pkg::CFG_CENTER_X, 32'h7fff_ffff);
    write_reg(pps_pkg::CFG_CENTER_Y, 32'h8000_0000);
    write_reg(pps_pkg::CFG_CENTER_Z, 32'h0);
    write_reg(pps_pkg::CFG_RADIUS, 32'h7fff_ffff);
    pending_vertices.push_back('{32'h8000_0000, 32'h7fff_ffff, 32'h5555_5555});
    pending_vertices.push_back('{32'h7fff_ffff, 32'h8000_0000, 32'h0});
    pending_vertices.push_back('{32'h7fff_fffe, 32'h8000_0001, 32'h1});
    queue_random(10);
    wait_drained();

    // radius zero
    write_reg(pps_pkg::CFG_RADIUS, 32'h0);
    queue_random(10);
    wait_drained();

    // random phases with idling patterns and random settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      write_reg(pps_pkg::CFG_CENTER_X, ph == 7 ? 32'h8000_0000 : $urandom());
      write_reg(pps_pkg::CFG_CENTER_Y,
                ph == 7 ? 32'h7fff_ffff : 32'($signed(16'($urandom()))));
      write_reg(pps_pkg::CFG_CENTER_Z, $urandom());
      write_reg(pps_pkg::CFG_RADIUS, ph == 6 ? 32'h1 : $urandom_range(1) ? $urandom() :
                $urandom_range(32'h0010_0000));
      queue_random(215);
      if (ph == 2) begin
        // long receiver hold-off while the sender keeps offering
        recv_hold = 1'b1;
        repeat (300) @(posedge clk);
        recv_hold = 1'b0;
      end
      wait_drained();
    end

    if (errors == 0)
      $display("[project_point_onto_sphere_core] OK");
    else
      $display("[project_point_onto_sphere_core] ERROR");
    $finish;
  end

endmodule

### sim.f
design/pps_pkg.sv
design/pps_sqrt.sv
design/pps_div.sv
design/project_point_onto_sphere_core.sv
dv/project_point_onto_sphere_core_tb.sv
